### design/pvd_pkg.sv
`timescale 1ns / 1ps
// Package for the prefixed varint decoder: item types, status codes,
// marker constants and the zigzag helper. No dependencies.
package pvd_pkg;

    // Largest first byte that is a value by itself.
    localparam logic [7:0] DIRECT_MAX = 8'h7f;
    localparam int unsigned NUM_MARKERS = 4;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_MARKER_ONE   = 2'd0,
        REG_MARKER_TWO   = 2'd1,
        REG_MARKER_FOUR  = 2'd2,
        REG_MARKER_EIGHT = 2'd3
    } reg_index_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RESERVED  = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } status_t;

    typedef logic [7:0] marker_arr_t [NUM_MARKERS];

    // Payload length announced by each marker, and marker reset codes.
    localparam logic [3:0] MARKER_LEN [NUM_MARKERS] = '{4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [7:0] MARKER_RESET [NUM_MARKERS] = '{8'hfc, 8'hfd, 8'hfe, 8'hff};

    // One accepted input byte with its side flags.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
        logic       zigzag;
    } in_item_t;

    // One decoded result.
    typedef struct packed {
        logic [63:0] value_bits;
        status_t     status;
    } result_t;

    // Zigzag decode: (z >> 1) ^ -(z & 1).
    function automatic logic [63:0] zigzag_decode(input logic [63:0] z);
        return {1'b0, z[63:1]} ^ {64{z[0]}};
    endfunction

endpackage

### design/pvd_in_stage.sv
`timescale 1ns / 1ps
// Input register of the prefixed varint decoder.
// Depends on pvd_pkg for the input item type.
module pvd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pvd_pkg::in_item_t in_item,
    input  logic              consume,
    output logic              item_valid,
    output pvd_pkg::in_item_t item
);
    import pvd_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // The register takes a new request when empty or when its item leaves now.
    assign in_ready   = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### design/pvd_decode.sv
`timescale 1ns / 1ps
// Decode logic and state of the prefixed varint decoder: marker registers,
// collection state and the per-byte result. Depends on pvd_pkg.
module pvd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic              fire,
    input  pvd_pkg::in_item_t item,
    output logic              res_valid,
    output pvd_pkg::result_t  result
);
    import pvd_pkg::*;

    marker_arr_t markers_reg;
    logic        collecting_reg, collecting_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [63:0] acc_reg, acc_next;
    logic        zz_latched_reg, zz_latched_next;

    logic [63:0] acc_shift;
    logic [3:0]  left_dec;
    logic        match;
    logic [3:0]  match_len;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            markers_reg <= MARKER_RESET;
        end
        else if (cfg_we)
        begin
            markers_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Marker match, shortest length first when codes are equal.
    always_comb
    begin
        match     = 1'b0;
        match_len = MARKER_LEN[0];
        for (int i = NUM_MARKERS - 1; i >= 0; i--)
        begin
            if (item.in_byte == markers_reg[i])
            begin
                match     = 1'b1;
                match_len = MARKER_LEN[i];
            end
        end
    end

    assign acc_shift = {acc_reg[55:0], item.in_byte};
    assign left_dec  = bytes_left_reg - 4'd1;

    // Next state and result for the byte in the input register.
    always_comb
    begin
        collecting_next = collecting_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        zz_latched_next = zz_latched_reg;
        res_valid       = 1'b0;
        result          = '{value_bits: 64'd0, status: STATUS_OK};
        if (collecting_reg)
        begin
            acc_next        = acc_shift;
            bytes_left_next = left_dec;
            if (left_dec == 4'd0)
            begin
                collecting_next = 1'b0;
                res_valid       = 1'b1;
                result.value_bits = zz_latched_reg ? zigzag_decode(acc_shift) : acc_shift;
            end
            else if (item.end_of_buffer)
            begin
                collecting_next = 1'b0;
                bytes_left_next = 4'd0;
                res_valid       = 1'b1;
                result.status   = STATUS_TRUNCATED;
            end
        end
        else if (item.in_byte <= DIRECT_MAX)
        begin
            res_valid         = 1'b1;
            result.value_bits = item.zigzag ? zigzag_decode({56'd0, item.in_byte})
                                            : {56'd0, item.in_byte};
        end
        else if (match)
        begin
            if (item.end_of_buffer)
            begin
                res_valid     = 1'b1;
                result.status = STATUS_TRUNCATED;
            end
            else
            begin
                collecting_next = 1'b1;
                bytes_left_next = match_len;
                acc_next        = 64'd0;
                zz_latched_next = item.zigzag;
            end
        end
        else
        begin
            res_valid     = 1'b1;
            result.status = STATUS_RESERVED;
        end
    end

    // State moves only when the byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            bytes_left_reg <= 4'd0;
            acc_reg        <= 64'd0;
            zz_latched_reg <= 1'b0;
        end
        else if (fire)
        begin
            collecting_reg <= collecting_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            zz_latched_reg <= zz_latched_next;
        end
    end

    // While gathering there is always at least one payload byte to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        collecting_reg |-> (bytes_left_reg != 4'd0 && bytes_left_reg <= 4'd8))
        else $error("collecting with bad byte count");

    // Error results carry a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result.status != STATUS_OK) |-> result.value_bits == 64'd0)
        else $error("error result with nonzero value");

    // Starting a value clears the accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !collecting_reg && collecting_next) |=> acc_reg == 64'd0)
        else $error("accumulator not cleared at value start");

endmodule

### design/pvd_out_stage.sv
`timescale 1ns / 1ps
// Result register of the prefixed varint decoder.
// Depends on pvd_pkg for the result type.
module pvd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  pvd_pkg::result_t result,
    output logic             can_take,
    output logic             out_valid,
    input  logic             out_ready,
    output pvd_pkg::result_t out_result
);
    import pvd_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // The register is free when empty or when its result is taken now.
    assign can_take   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_take)
        begin
            result_reg <= result;
        end
    end

endmodule

### design/prefixed_varint_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the prefixed varint decoder.
// Depends on pvd_pkg, pvd_in_stage, pvd_decode and pvd_out_stage.
//
// Usage: encoded bytes arrive on the s_ stream, one byte per request, with
// tlast marking the last byte of the buffer and tuser the zigzag flag.
// A first byte up to 0x7f is a value; a byte equal to one of the four marker
// registers announces 1, 2, 4 or 8 big-endian payload bytes. Decoded values
// leave on the m_ stream with the status code in tuser; error results carry
// a zero value. Bytes that open or continue a value give no result.
// A result's last byte is first held in the input register, and the decode
// pass loads the result register from it once that register can take it.
// Throughput: one byte per cycle unless a result waits on a stalled receiver,
// set by the single decode pass between the two registers.
// Reset clears the collection state and loads the markers with 0xfc, 0xfd,
// 0xfe and 0xff. The user writes marker registers through cfg_we, cfg_index
// and cfg_wdata only while the stream is idle; the block does not check it.
// When the receiver stalls, the result register holds its result and the
// input register still takes bytes that give no result; a byte that would
// give a result waits in the input register and s_tready drops.
module prefixed_varint_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_buffer
    input  logic        s_tuser,   // [0] zigzag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value_bits
    output logic [1:0]  m_tuser    // [1:0] status
);
    import pvd_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     res_valid;
    result_t  result;
    result_t  out_result;
    logic     can_take;
    logic     consume;

    assign in_item = '{in_byte: s_tdata, end_of_buffer: s_tlast, zigzag: s_tuser};

    // A byte leaves the input register when its result, if any, can be stored.
    assign consume = item_valid && (can_take || !res_valid);

    pvd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    pvd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (consume),
        .item      (item),
        .res_valid (res_valid),
        .result    (result)
    );

    pvd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume && res_valid),
        .result     (result),
        .can_take   (can_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = out_result.value_bits;
    assign m_tuser = out_result.status;

endmodule

### verif/prefixed_varint_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for prefixed_varint_decoder_unit: directed and random byte
// streams under random idling on both stream sides and several marker settings.
// Depends on pvd_pkg and the decoder RTL only.
module prefixed_varint_decoder_unit_test;
    import pvd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_SETTLE = 4;
    localparam int MAX_PRINTED = 40;
    localparam reg_index_t REG_ORDER [NUM_MARKERS] =
        '{REG_MARKER_ONE, REG_MARKER_TWO, REG_MARKER_FOUR, REG_MARKER_EIGHT};

    // Mirror of the decoder: marker codes, collection state and the
    // results still owed by the block, oldest first.
    class varint_scoreboard;
        logic [7:0]  marker_code [NUM_MARKERS];
        bit          gathering;
        logic [3:0]  remaining;
        logic [63:0] acc;
        bit          zz_held;
        result_t     owed_results [$];
        int          errors;
        int          checked;
        int          n_ok;
        int          n_reserved;
        int          n_truncated;

        function new();
            for (int i = 0; i < NUM_MARKERS; i++)
                marker_code[i] = MARKER_RESET[i];
            gathering = 0;
            remaining = '0;
            acc = '0;
            zz_held = 0;
            errors = 0;
            checked = 0;
            n_ok = 0;
            n_reserved = 0;
            n_truncated = 0;
        endfunction

        function void set_marker(int idx, logic [7:0] code);
            marker_code[idx] = code;
        endfunction

        // Payload length announced by a first byte, 0 if it is no marker.
        // With duplicate codes the shortest length takes precedence.
        function int payload_len(logic [7:0] b);
            for (int i = 0; i < NUM_MARKERS; i++)
                if (b == marker_code[i])
                    return int'(MARKER_LEN[i]);
            return 0;
        endfunction

        function logic [63:0] unzig(logic [63:0] z, bit zz);
            if (!zz)
                return z;
            return (z >> 1) ^ (64'd0 - {63'd0, z[0]});
        endfunction

        function void owe(logic [63:0] v, status_t st);
            result_t r;
            r.value_bits = v;
            r.status = st;
            owed_results.push_back(r);
        endfunction

        // Advance the mirror by one accepted byte.
        function void note_byte(in_item_t it);
            int len;
            if (gathering) begin
                acc = {acc[55:0], it.in_byte};
                remaining = remaining - 4'd1;
                if (remaining == 4'd0) begin
                    gathering = 0;
                    owe(unzig(acc, zz_held), STATUS_OK);
                end
                else if (it.end_of_buffer) begin
                    gathering = 0;
                    remaining = '0;
                    owe('0, STATUS_TRUNCATED);
                end
            end
            else if (it.in_byte <= DIRECT_MAX) begin
                owe(unzig({56'd0, it.in_byte}, it.zigzag), STATUS_OK);
            end
            else begin
                len = payload_len(it.in_byte);
                if (len == 0)
                    owe('0, STATUS_RESERVED);
                else if (it.end_of_buffer)
                    owe('0, STATUS_TRUNCATED);
                else begin
                    gathering = 1;
                    remaining = 4'(len);
                    acc = '0;
                    zz_held = it.zigzag;
                end
            end
        endfunction

        function void report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH: %s", what);
            else if (errors == MAX_PRINTED + 1)
                $display("Further mismatches are counted but not printed.");
        endfunction

        // Compare one accepted result with the oldest owed one.
        function void check_result(logic [63:0] v, logic [1:0] st);
            result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result value=%h status=%0d", v, st));
                return;
            end
            want = owed_results.pop_front();
            checked++;
            case (want.status)
                STATUS_OK:        n_ok++;
                STATUS_RESERVED:  n_reserved++;
                default:          n_truncated++;
            endcase
            if (v !== want.value_bits)
                report($sformatf("result %0d value %h, expected %h",
                                 checked, v, want.value_bits));
            if (st !== want.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 checked, st, want.status));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    varint_scoreboard sb;
    bit tx_quiet = 0;
    bit rx_quiet = 0;
    int bytes_sent = 0;
    int settings_used = 1;
    int cycle_count = 0;

    prefixed_varint_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.owed_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Send one byte as a request, after a random gap; valid stays high
    // across back-to-back requests.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic zz);
        int gap;
        in_item_t it;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        s_tuser <= zz;
        do @(posedge clk); while (!s_tready);
        it.in_byte = b;
        it.end_of_buffer = last;
        it.zigzag = zz;
        sb.note_byte(it);
        bytes_sent++;
    endtask

    // Drop valid and wait until every owed result has left the block,
    // plus the pipeline depth for bytes that give no result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_markers(input marker_arr_t codes);
        wait_idle();
        for (int i = 0; i < NUM_MARKERS; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= codes[i];
            @(posedge clk);
            sb.set_marker(i, codes[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed values with random content; some noise bytes,
    // reserved first bytes and values cut short by the end of the buffer.
    task automatic send_value();
        int pick;
        int k;
        int len;
        int cut;
        int n;
        logic [7:0] b;
        logic [7:0] pay;
        logic zz;
        logic last;
        pick = $urandom_range(0, 99);
        zz = 1'($urandom_range(0, 1));
        if (pick < 10) begin
            send_byte(8'($urandom), ($urandom_range(0, 3) == 0), zz);
        end
        else if (pick < 30) begin
            send_byte(8'($urandom_range(0, 127)), ($urandom_range(0, 3) == 0), zz);
        end
        else if (pick < 38) begin
            send_byte(8'($urandom_range(128, 255)), ($urandom_range(0, 3) == 0), zz);
        end
        else begin
            k = $urandom_range(0, NUM_MARKERS - 1);
            b = sb.marker_code[k];
            len = sb.payload_len(b);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
            send_byte(b, (cut == 0), zz);
            n = (cut == len) ? len : cut;
            for (int j = 1; j <= n; j++) begin
                case ($urandom_range(0, 7))
                    0:       pay = 8'h00;
                    1:       pay = 8'hff;
                    default: pay = 8'($urandom);
                endcase
                if (j == cut && cut < len)
                    last = 1'b1;
                else if (j == len)
                    last = 1'($urandom_range(0, 1));
                else
                    last = 1'b0;
                send_byte(pay, last, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic send_random(input int count);
        int stop;
        stop = bytes_sent + count;
        while (bytes_sent < stop)
            send_value();
    endtask

    // Result side: random stalls, with stretches of none.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // Main sequence.
    initial
    begin
        marker_arr_t codes;
        sb = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MARKER_ONE;
        cfg_wdata <= 8'h00;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tlast <= 1'b0;
        s_tuser <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Direct values at both ends, with and without zigzag.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(DIRECT_MAX, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(DIRECT_MAX, 1'b1, 1'b1);
        // Eight payload bytes of all ones, end of buffer on the final one.
        send_byte(MARKER_RESET[3], 1'b0, 1'b0);
        for (int j = 1; j <= 8; j++)
            send_byte(8'hff, (j == 8), 1'b1);
        // One payload byte, zigzag latched from the marker.
        send_byte(MARKER_RESET[0], 1'b0, 1'b1);
        send_byte(8'hff, 1'b0, 1'b0);
        // Reserved first byte.
        send_byte(8'h80, 1'b1, 1'b0);
        // Buffer ends on a marker, then in the middle of a payload.
        send_byte(MARKER_RESET[1], 1'b1, 1'b0);
        send_byte(MARKER_RESET[2], 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b1, 1'b0);
        // Two payload bytes with zigzag.
        send_byte(MARKER_RESET[1], 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);

        send_random(250);

        codes = '{8'h80, 8'h81, 8'h82, 8'h83};
        write_markers(codes);
        send_random(200);

        codes = '{8'hff, 8'hfe, 8'hfd, 8'hfc};
        write_markers(codes);
        send_random(200);

        // Duplicate codes: the shorter length must take precedence.
        codes = '{8'h80, 8'h80, 8'hff, 8'hff};
        write_markers(codes);
        send_random(200);

        codes = '{8'hc0, 8'hc0, 8'hc0, 8'hc0};
        write_markers(codes);
        send_random(200);

        for (int i = 0; i < NUM_MARKERS; i++)
            codes[i] = 8'($urandom_range(128, 255));
        write_markers(codes);
        send_random(200);

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes under %0d marker settings; checked %0d results.",
                 bytes_sent, settings_used, sb.checked);
        $display("Results by status: %0d ok, %0d reserved, %0d truncated.",
                 sb.n_ok, sb.n_reserved, sb.n_truncated);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
